// File: rtl/core/npc_pkg.sv
// ---------------------------------------------------------------------------
// npc_pkg: shared types and constants of the nearest palette color core
// Holds the fixed 256-entry RGB palette, field widths and the
// controller/datapath command and status structs.
// ---------------------------------------------------------------------------
`default_nettype none

package npc_pkg;

    localparam int COLOR_W                 = 8;
    localparam int INDEX_W                 = 8;
    localparam int ROM_ROWS                = 256;
    localparam int DEFAULT_PALETTE_ENTRIES = 256;
    // 3 * 255 * 255 fits in 18 bits
    localparam int SQ_W                    = 2 * COLOR_W;
    localparam int DIST_W                  = SQ_W + 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } npc_state_t;

    typedef struct packed {
        logic load_pixel;
        logic issue;
        logic load_out;
    } npc_cmd_t;

    typedef struct packed {
        logic last_issue;
        logic pipe_busy;
        logic out_free;
    } npc_status_t;

    // packed as 24'hRRGGBB
    localparam logic [3*COLOR_W-1:0] PALETTE_ROM [ROM_ROWS] = '{
        24'h000000, 24'h0002AA, 24'h14AA00, 24'h00AAAA, 24'hAA0003,
        24'hAA00AA, 24'hAA5500, 24'hAAAAAA, 24'h555555, 24'h5555FF,
        24'h55FF55, 24'h55FFFF, 24'hFF5555, 24'hFD55FF, 24'hFFFF55,
        24'hFFFFFF, 24'h000000, 24'h101010, 24'h202020, 24'h353535,
        24'h454545, 24'h555555, 24'h656565, 24'h757575, 24'h8A8A8A,
        24'h9A9A9A, 24'hAAAAAA, 24'hBABABA, 24'hCACACA, 24'hDFDFDF,
        24'hEFEFEF, 24'hFFFFFF, 24'h0004FF, 24'h4104FF, 24'h8203FF,
        24'hBE02FF, 24'hFD00FF, 24'hFE00BE, 24'hFF0082, 24'hFF0041,
        24'hFF0008, 24'hFF4105, 24'hFF8200, 24'hFFBE00, 24'hFFFF00,
        24'hBEFF00, 24'h82FF00, 24'h41FF01, 24'h24FF00, 24'h22FF42,
        24'h1DFF82, 24'h12FFBE, 24'h00FFFF, 24'h00BEFF, 24'h0182FF,
        24'h0041FF, 24'h8282FF, 24'h9E82FF, 24'hBE82FF, 24'hDF82FF,
        24'hFD82FF, 24'hFE82DF, 24'hFF82BE, 24'hFF829E, 24'hFF8282,
        24'hFF9E82, 24'hFFBE82, 24'hFFDF82, 24'hFFFF82, 24'hDFFF82,
        24'hBEFF82, 24'h9EFF82, 24'h82FF82, 24'h82FF9E, 24'h82FFBE,
        24'h82FFDF, 24'h82FFFF, 24'h82DFFF, 24'h82BEFF, 24'h829EFF,
        24'hBABAFF, 24'hCABAFF, 24'hDFBAFF, 24'hEFBAFF, 24'hFEBAFF,
        24'hFEBAEF, 24'hFFBADF, 24'hFFBACA, 24'hFFBABA, 24'hFFCABA,
        24'hFFDFBA, 24'hFFEFBA, 24'hFFFFBA, 24'hEFFFBA, 24'hDFFFBA,
        24'hCAFFBB, 24'hBAFFBA, 24'hBAFFCA, 24'hBAFFDF, 24'hBAFFEF,
        24'hBAFFFF, 24'hBAEFFF, 24'hBADFFF, 24'hBACAFF, 24'h010171,
        24'h1C0171, 24'h390171, 24'h550071, 24'h710071, 24'h710055,
        24'h710039, 24'h71001C, 24'h710001, 24'h711C01, 24'h713900,
        24'h715500, 24'h717100, 24'h557100, 24'h397100, 24'h1C7100,
        24'h097100, 24'h09711C, 24'h067139, 24'h037155, 24'h007171,
        24'h005571, 24'h003971, 24'h001C71, 24'h393971, 24'h453971,
        24'h553971, 24'h613971, 24'h713971, 24'h713961, 24'h713955,
        24'h713945, 24'h713939, 24'h714539, 24'h715539, 24'h716139,
        24'h717139, 24'h617139, 24'h557139, 24'h45713A, 24'h397139,
        24'h397145, 24'h397155, 24'h397161, 24'h397171, 24'h396171,
        24'h395571, 24'h394572, 24'h515171, 24'h595171, 24'h615171,
        24'h695171, 24'h715171, 24'h715169, 24'h715161, 24'h715159,
        24'h715151, 24'h715951, 24'h716151, 24'h716951, 24'h717151,
        24'h697151, 24'h617151, 24'h597151, 24'h517151, 24'h51715A,
        24'h517161, 24'h517169, 24'h517171, 24'h516971, 24'h516171,
        24'h515971, 24'h000042, 24'h110041, 24'h200041, 24'h310041,
        24'h410041, 24'h410032, 24'h410020, 24'h410010, 24'h410000,
        24'h411000, 24'h412000, 24'h413100, 24'h414100, 24'h314100,
        24'h204100, 24'h104100, 24'h034100, 24'h034110, 24'h024120,
        24'h014131, 24'h004141, 24'h003141, 24'h002041, 24'h001041,
        24'h202041, 24'h282041, 24'h312041, 24'h392041, 24'h412041,
        24'h412039, 24'h412031, 24'h412028, 24'h412020, 24'h412820,
        24'h413120, 24'h413921, 24'h414120, 24'h394120, 24'h314120,
        24'h284120, 24'h204120, 24'h204128, 24'h204131, 24'h204139,
        24'h204141, 24'h203941, 24'h203141, 24'h202841, 24'h2D2D41,
        24'h312D41, 24'h352D41, 24'h3D2D41, 24'h412D41, 24'h412D3D,
        24'h412D35, 24'h412D31, 24'h412D2D, 24'h41312D, 24'h41352D,
        24'h413D2D, 24'h41412D, 24'h3D412D, 24'h35412D, 24'h31412D,
        24'h2D412D, 24'h2D4131, 24'h2D4135, 24'h2D413D, 24'h2D4141,
        24'h2D3D41, 24'h2D3541, 24'h2D3141, 24'h000000, 24'h000000,
        24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
        24'h000000
    };

endpackage

`default_nettype wire

// File: rtl/core/npc_ctrl.sv
// ---------------------------------------------------------------------------
// npc_ctrl: search sequencer
// Accepts a pixel, runs the palette scan, waits for the distance pipeline
// to drain and hands the winning index to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module npc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire npc_pkg::npc_status_t status,
    output npc_pkg::npc_cmd_t        cmd
);

    import npc_pkg::*;

    npc_state_t state_reg;
    npc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.last_issue)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!status.pipe_busy && status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall       = 1'b1;
        cmd.load_pixel = 1'b0;
        cmd.issue      = 1'b0;
        cmd.load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall       = 1'b0;
                cmd.load_pixel = in_valid;
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
            end
            ST_FLUSH:
            begin
                cmd.load_out = !status.pipe_busy && status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/npc_datapath.sv
// ---------------------------------------------------------------------------
// npc_datapath: distance pipeline and best-match tracking
// Three stages per palette entry: absolute differences, squares, then
// sum and strict compare against the held best. Output register at the end.
// ---------------------------------------------------------------------------
`default_nettype none

module npc_datapath #(
    parameter int PALETTE_ENTRIES = npc_pkg::DEFAULT_PALETTE_ENTRIES
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [npc_pkg::COLOR_W-1:0]   red,
    input  wire logic [npc_pkg::COLOR_W-1:0]   green,
    input  wire logic [npc_pkg::COLOR_W-1:0]   blue,
    input  wire npc_pkg::npc_cmd_t             cmd,
    output npc_pkg::npc_status_t               status,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [npc_pkg::INDEX_W-1:0]        palette_index
);

    import npc_pkg::*;

    localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

    // pixel and scan counter
    logic [COLOR_W-1:0] pix_r_reg;
    logic [COLOR_W-1:0] pix_g_reg;
    logic [COLOR_W-1:0] pix_b_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;

    // stage 1: absolute differences
    logic               s1_valid_reg;
    logic               s1_first_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic [COLOR_W-1:0] s1_dr_reg;
    logic [COLOR_W-1:0] s1_dg_reg;
    logic [COLOR_W-1:0] s1_db_reg;
    logic [COLOR_W-1:0] dr_next;
    logic [COLOR_W-1:0] dg_next;
    logic [COLOR_W-1:0] db_next;
    logic [3*COLOR_W-1:0] rom_entry;

    // stage 2: squares
    logic               s2_valid_reg;
    logic               s2_first_reg;
    logic [IDX_W-1:0]   s2_idx_reg;
    logic [SQ_W-1:0]    s2_sr_reg;
    logic [SQ_W-1:0]    s2_sg_reg;
    logic [SQ_W-1:0]    s2_sb_reg;

    // stage 3: best match
    logic [DIST_W-1:0]  sum_dist;
    logic               take_best;
    logic [DIST_W-1:0]  best_dist_reg;
    logic [IDX_W-1:0]   best_idx_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [INDEX_W-1:0] palette_index_reg;

    function automatic logic [COLOR_W-1:0] abs_diff(
        input logic [COLOR_W-1:0] a,
        input logic [COLOR_W-1:0] b
    );
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    assign rom_entry = PALETTE_ROM[INDEX_W'(idx_reg)];
    assign dr_next   = abs_diff(pix_r_reg, rom_entry[3*COLOR_W-1:2*COLOR_W]);
    assign dg_next   = abs_diff(pix_g_reg, rom_entry[2*COLOR_W-1:COLOR_W]);
    assign db_next   = abs_diff(pix_b_reg, rom_entry[COLOR_W-1:0]);

    assign sum_dist  = DIST_W'(s2_sr_reg) + DIST_W'(s2_sg_reg) + DIST_W'(s2_sb_reg);
    // strictly smaller only, so the lowest index keeps a tie
    assign take_best = s2_valid_reg && (s2_first_reg || (sum_dist < best_dist_reg));

    always_comb
    begin
        priority if (cmd.load_pixel)
        begin
            idx_next = '0;
        end
        else if (cmd.issue)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    always_comb
    begin
        priority if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            s1_valid_reg  <= cmd.issue;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_pixel)
        begin
            pix_r_reg <= red;
            pix_g_reg <= green;
            pix_b_reg <= blue;
        end
        s1_first_reg <= (idx_reg == '0);
        s1_idx_reg   <= idx_reg;
        s1_dr_reg    <= dr_next;
        s1_dg_reg    <= dg_next;
        s1_db_reg    <= db_next;
        s2_first_reg <= s1_first_reg;
        s2_idx_reg   <= s1_idx_reg;
        s2_sr_reg    <= SQ_W'(s1_dr_reg) * SQ_W'(s1_dr_reg);
        s2_sg_reg    <= SQ_W'(s1_dg_reg) * SQ_W'(s1_dg_reg);
        s2_sb_reg    <= SQ_W'(s1_db_reg) * SQ_W'(s1_db_reg);
        if (take_best)
        begin
            best_dist_reg <= sum_dist;
            best_idx_reg  <= s2_idx_reg;
        end
        if (cmd.load_out)
        begin
            palette_index_reg <= INDEX_W'(best_idx_reg);
        end
    end

    assign status.last_issue = cmd.issue && (idx_reg == LAST_IDX);
    assign status.pipe_busy  = s1_valid_reg || s2_valid_reg;
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign palette_index = palette_index_reg;

    a_issue_enters_pipe: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.issue |=> s1_valid_reg
    ) else $error("issued entry did not enter the distance pipeline");

    a_result_after_drain: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!s1_valid_reg && !s2_valid_reg)
    ) else $error("result loaded while distances still in flight");

    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !out_stall)
    ) else $error("output register overwritten while stalled");

    a_scan_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (idx_reg <= LAST_IDX)
    ) else $error("scan index past last palette entry");

endmodule

`default_nettype wire

// File: rtl/core/nearest_palette_color_core.sv
// ---------------------------------------------------------------------------
// nearest_palette_color_core: nearest palette entry for one RGB pixel
// Top level joining the search sequencer and the distance datapath.
// ---------------------------------------------------------------------------
// Each request carries one 24-bit pixel and yields one 8-bit index of the
// closest of the first PALETTE_ENTRIES palette colors by summed squared RGB
// difference, the lowest index winning on ties. A new request is taken only
// after the last one is done: the single distance pipeline scores one
// palette entry per cycle, then drains and loads the output register. A
// finished result may sit in the output register while the next pixel is
// accepted.
`default_nettype none

module nearest_palette_color_core #(
    parameter int PALETTE_ENTRIES = npc_pkg::DEFAULT_PALETTE_ENTRIES
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [npc_pkg::COLOR_W-1:0]   red,
    input  wire logic [npc_pkg::COLOR_W-1:0]   green,
    input  wire logic [npc_pkg::COLOR_W-1:0]   blue,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [npc_pkg::INDEX_W-1:0]        palette_index
);

    import npc_pkg::*;

    npc_cmd_t    cmd;
    npc_status_t status;

    npc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    npc_datapath #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .palette_index (palette_index)
    );

endmodule

`default_nettype wire

// File: verif/nearest_palette_color_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nearest_palette_color_core testbench
// Sends RGB pixels through the valid/stall input, scores every pixel against
// its own copy of the palette and checks each returned index in order. Both
// sides idle at random, and the receiver once holds off long enough to back
// the core up into its input.
// ---------------------------------------------------------------------------

module tb;

    typedef logic [npc_pkg::COLOR_W-1:0] color_t;
    typedef logic [npc_pkg::INDEX_W-1:0] index_t;

    localparam int SEARCH_ROWS  = 256;
    localparam int RANDOM_PIXELS = 400;
    localparam int HOLD_CYCLES  = 2000;
    localparam int CYCLE_LIMIT  = 1000000;

    // 24'hRRGGBB
    localparam logic [23:0] PALETTE_RGB [256] = '{
        24'h000000, 24'h0002AA, 24'h14AA00, 24'h00AAAA, 24'hAA0003,
        24'hAA00AA, 24'hAA5500, 24'hAAAAAA, 24'h555555, 24'h5555FF,
        24'h55FF55, 24'h55FFFF, 24'hFF5555, 24'hFD55FF, 24'hFFFF55,
        24'hFFFFFF, 24'h000000, 24'h101010, 24'h202020, 24'h353535,
        24'h454545, 24'h555555, 24'h656565, 24'h757575, 24'h8A8A8A,
        24'h9A9A9A, 24'hAAAAAA, 24'hBABABA, 24'hCACACA, 24'hDFDFDF,
        24'hEFEFEF, 24'hFFFFFF, 24'h0004FF, 24'h4104FF, 24'h8203FF,
        24'hBE02FF, 24'hFD00FF, 24'hFE00BE, 24'hFF0082, 24'hFF0041,
        24'hFF0008, 24'hFF4105, 24'hFF8200, 24'hFFBE00, 24'hFFFF00,
        24'hBEFF00, 24'h82FF00, 24'h41FF01, 24'h24FF00, 24'h22FF42,
        24'h1DFF82, 24'h12FFBE, 24'h00FFFF, 24'h00BEFF, 24'h0182FF,
        24'h0041FF, 24'h8282FF, 24'h9E82FF, 24'hBE82FF, 24'hDF82FF,
        24'hFD82FF, 24'hFE82DF, 24'hFF82BE, 24'hFF829E, 24'hFF8282,
        24'hFF9E82, 24'hFFBE82, 24'hFFDF82, 24'hFFFF82, 24'hDFFF82,
        24'hBEFF82, 24'h9EFF82, 24'h82FF82, 24'h82FF9E, 24'h82FFBE,
        24'h82FFDF, 24'h82FFFF, 24'h82DFFF, 24'h82BEFF, 24'h829EFF,
        24'hBABAFF, 24'hCABAFF, 24'hDFBAFF, 24'hEFBAFF, 24'hFEBAFF,
        24'hFEBAEF, 24'hFFBADF, 24'hFFBACA, 24'hFFBABA, 24'hFFCABA,
        24'hFFDFBA, 24'hFFEFBA, 24'hFFFFBA, 24'hEFFFBA, 24'hDFFFBA,
        24'hCAFFBB, 24'hBAFFBA, 24'hBAFFCA, 24'hBAFFDF, 24'hBAFFEF,
        24'hBAFFFF, 24'hBAEFFF, 24'hBADFFF, 24'hBACAFF, 24'h010171,
        24'h1C0171, 24'h390171, 24'h550071, 24'h710071, 24'h710055,
        24'h710039, 24'h71001C, 24'h710001, 24'h711C01, 24'h713900,
        24'h715500, 24'h717100, 24'h557100, 24'h397100, 24'h1C7100,
        24'h097100, 24'h09711C, 24'h067139, 24'h037155, 24'h007171,
        24'h005571, 24'h003971, 24'h001C71, 24'h393971, 24'h453971,
        24'h553971, 24'h613971, 24'h713971, 24'h713961, 24'h713955,
        24'h713945, 24'h713939, 24'h714539, 24'h715539, 24'h716139,
        24'h717139, 24'h617139, 24'h557139, 24'h45713A, 24'h397139,
        24'h397145, 24'h397155, 24'h397161, 24'h397171, 24'h396171,
        24'h395571, 24'h394572, 24'h515171, 24'h595171, 24'h615171,
        24'h695171, 24'h715171, 24'h715169, 24'h715161, 24'h715159,
        24'h715151, 24'h715951, 24'h716151, 24'h716951, 24'h717151,
        24'h697151, 24'h617151, 24'h597151, 24'h517151, 24'h51715A,
        24'h517161, 24'h517169, 24'h517171, 24'h516971, 24'h516171,
        24'h515971, 24'h000042, 24'h110041, 24'h200041, 24'h310041,
        24'h410041, 24'h410032, 24'h410020, 24'h410010, 24'h410000,
        24'h411000, 24'h412000, 24'h413100, 24'h414100, 24'h314100,
        24'h204100, 24'h104100, 24'h034100, 24'h034110, 24'h024120,
        24'h014131, 24'h004141, 24'h003141, 24'h002041, 24'h001041,
        24'h202041, 24'h282041, 24'h312041, 24'h392041, 24'h412041,
        24'h412039, 24'h412031, 24'h412028, 24'h412020, 24'h412820,
        24'h413120, 24'h413921, 24'h414120, 24'h394120, 24'h314120,
        24'h284120, 24'h204120, 24'h204128, 24'h204131, 24'h204139,
        24'h204141, 24'h203941, 24'h203141, 24'h202841, 24'h2D2D41,
        24'h312D41, 24'h352D41, 24'h3D2D41, 24'h412D41, 24'h412D3D,
        24'h412D35, 24'h412D31, 24'h412D2D, 24'h41312D, 24'h41352D,
        24'h413D2D, 24'h41412D, 24'h3D412D, 24'h35412D, 24'h31412D,
        24'h2D412D, 24'h2D4131, 24'h2D4135, 24'h2D413D, 24'h2D4141,
        24'h2D3D41, 24'h2D3541, 24'h2D3141, 24'h000000, 24'h000000,
        24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
        24'h000000
    };

    class palette_scoreboard;
        index_t nearest_q[$];
        int     errors;
        int     indexes_checked;

        function automatic index_t nearest_index(color_t r, color_t g, color_t b);
            int dr;
            int dg;
            int db;
            int row_dist;
            int best_dist;
            index_t best;
            best = '0;
            best_dist = 0;
            for (int row = 0; row < SEARCH_ROWS; row++)
            begin
                dr = int'(r) - int'(PALETTE_RGB[row][23:16]);
                dg = int'(g) - int'(PALETTE_RGB[row][15:8]);
                db = int'(b) - int'(PALETTE_RGB[row][7:0]);
                row_dist = dr * dr + dg * dg + db * db;
                // strictly smaller only, so ties keep the lowest index
                if (row == 0 || row_dist < best_dist)
                begin
                    best_dist = row_dist;
                    best = index_t'(row);
                end
            end
            return best;
        endfunction

        function void note_pixel(color_t r, color_t g, color_t b);
            nearest_q.push_back(nearest_index(r, g, b));
        endfunction

        function void check_index(index_t got);
            index_t want;
            indexes_checked++;
            if (nearest_q.size() == 0)
            begin
                errors++;
                $display("%0t: palette_index %0d with no request pending, expected none",
                         $time, got);
            end
            else
            begin
                want = nearest_q.pop_front();
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: palette_index mismatch, expected %0d, actual %0d",
                             $time, want, got);
                end
            end
        endfunction
    endclass

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_stall;
    color_t red;
    color_t green;
    color_t blue;
    logic   out_valid;
    logic   out_stall;
    index_t palette_index;

    palette_scoreboard sb;
    bit hold_off;
    int requests_sent;
    int cycles;

    nearest_palette_color_core #(
        .PALETTE_ENTRIES(SEARCH_ROWS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .palette_index(palette_index)
    );

    initial
    begin
        clk = 1'b0;
        sb = new();
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_pixel(red, green, blue);
        if (rst_n && out_valid && !out_stall)
            sb.check_index(palette_index);
    end

    function automatic int draw_gap(bit steady);
        return steady ? 0 : $urandom_range(9, 0);
    endfunction

    function automatic color_t nudge(color_t c);
        int v;
        v = int'(c) + $urandom_range(16, 0) - 8;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return color_t'(v);
    endfunction

    task automatic send_pixel(color_t r, color_t g, color_t b, bit steady);
        int gap;
        gap = draw_gap(steady);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            red      <= color_t'($urandom);
            green    <= color_t'($urandom);
            blue     <= color_t'($urandom);
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        red      <= r;
        green    <= g;
        blue     <= b;
        do
            @(posedge clk);
        while (in_stall);
        requests_sent++;
        @(negedge clk);
    endtask

    // receiver: random stall per result, a quiet stretch, and the long hold-off
    initial
    begin : receiver
        int  gap;
        bit  steady;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            steady = sb.indexes_checked >= 300 && sb.indexes_checked < 360;
            gap = draw_gap(steady);
            if (gap > 0 || hold_off)
            begin
                out_stall <= 1'b1;
                // sometimes start the stall count only once a result is up
                if ($urandom_range(1, 0) == 1)
                begin
                    do
                        @(posedge clk);
                    while (!out_valid);
                    @(negedge clk);
                end
                repeat (gap) @(negedge clk);
                while (hold_off)
                    @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin : long_hold
        hold_off = 1'b0;
        while (requests_sent < 100)
            @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin : stimulus
        logic [23:0] pa;
        logic [23:0] pb;
        color_t r;
        color_t g;
        color_t b;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        red       = '0;
        green     = '0;
        blue      = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // black and white have duplicates further up the table
        send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd0,   8'd0,   1'b0);
        send_pixel(8'd0,   8'd255, 8'd0,   1'b0);
        send_pixel(8'd0,   8'd0,   8'd255, 1'b0);
        // equal distance to entries 0 and 17
        send_pixel(8'd8,   8'd8,   8'd8,   1'b0);
        send_pixel(8'd85,  8'd85,  8'd85,  1'b0);
        send_pixel(8'd170, 8'd170, 8'd170, 1'b0);
        send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
        send_pixel(8'd127, 8'd127, 8'd127, 1'b0);
        send_pixel(8'hAA,  8'h55,  8'hAA,  1'b0);
        send_pixel(8'h55,  8'hAA,  8'h55,  1'b0);
        send_pixel(8'd1,   8'd2,   8'd4,   1'b0);
        send_pixel(8'd254, 8'd253, 8'd251, 1'b0);
        send_pixel(8'd113, 8'd0,   8'd113, 1'b0);
        send_pixel(8'd65,  8'd65,  8'd65,  1'b0);
        send_pixel(8'd255, 8'd255, 8'd0,   1'b0);
        send_pixel(8'd0,   8'd255, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd0,   8'd255, 1'b0);
        send_pixel(8'd45,  8'd65,  8'd65,  1'b0);

        for (int n = 0; n < RANDOM_PIXELS; n++)
        begin
            pa = PALETTE_RGB[$urandom_range(255, 0)];
            pb = PALETTE_RGB[$urandom_range(255, 0)];
            case ($urandom_range(3, 0))
                0:
                begin
                    r = color_t'($urandom);
                    g = color_t'($urandom);
                    b = color_t'($urandom);
                end
                1:
                begin
                    r = pa[23:16];
                    g = pa[15:8];
                    b = pa[7:0];
                end
                2:
                begin
                    r = nudge(pa[23:16]);
                    g = nudge(pa[15:8]);
                    b = nudge(pa[7:0]);
                end
                default:
                begin
                    // halfway between two entries, where ties are likely
                    r = color_t'((int'(pa[23:16]) + int'(pb[23:16])) / 2);
                    g = color_t'((int'(pa[15:8]) + int'(pb[15:8])) / 2);
                    b = color_t'((int'(pa[7:0]) + int'(pb[7:0])) / 2);
                end
            endcase
            send_pixel(r, g, b, n >= 200 && n < 260);
        end
        in_valid <= 1'b0;

        while (sb.nearest_q.size() != 0)
            @(posedge clk);
        repeat (SEARCH_ROWS + 20) @(posedge clk);

        if (sb.errors == 0 && sb.nearest_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
